>>> src/wsfhp_pkg.sv
// Shared types and constants for the WebSocket frame header parser.
package wsfhp_pkg;

    localparam logic [6:0] LEN_MASK    = 7'h7f;
    localparam logic [3:0] OPCODE_MASK = 4'hf;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] BASE_HDR_LEN = 4'd2;
    localparam logic [3:0] EXT16_LEN    = 4'd2;
    localparam logic [3:0] EXT64_LEN    = 4'd8;
    localparam logic [3:0] KEY_LEN      = 4'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } rx_item_t;

    typedef struct packed {
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [31:0] masking_key;
        logic [3:0]  header_length;
        logic [63:0] frame_length;
    } hdr_item_t;

    // Parsed header as it travels from the front part to the back part
    typedef struct packed {
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [31:0] masking_key;
        logic [3:0]  header_length;
    } hdr_rec_t;

    typedef struct packed {
        logic     valid;
        hdr_rec_t rec;
    } hdr_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [3:0] ext_len(input logic [6:0] code);
        logic [3:0] len;
        len = 4'd0;
        if (code == LEN_CODE_16)
        begin
            len = EXT16_LEN;
        end
        else if (code == LEN_CODE_64)
        begin
            len = EXT64_LEN;
        end
        return len;
    endfunction

endpackage

>>> src/websocket_frame_header_parser.sv
// WebSocket frame header parser: one header byte per item, one result per header.
// Throughput: one byte every cycle; the parser stalls only when the header queue is full.
// Result path: a completed header is written into the queue as its last byte is accepted,
// then passes the frame-length adder into the output register once that register is empty
// or its item is being taken.
// Reset: asynchronous, active low; clears the parser state, queue pointers and output valid.
module websocket_frame_header_parser
    import wsfhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    output logic      rx_ready,
    input  rx_item_t  rx_item,
    output logic      hdr_valid,
    input  logic      hdr_ready,
    output hdr_item_t hdr_item
);

    hdr_push_t     push;
    queue_status_t status;
    hdr_rec_t      head;
    logic          pop;

    assign rx_ready = !status.full;

    wsfhp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (rx_valid && rx_ready),
        .item  (rx_item),
        .push  (push)
    );

    wsfhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (status),
        .head   (head)
    );

    wsfhp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .head   (head),
        .pop    (pop),
        .valid  (hdr_valid),
        .ready  (hdr_ready),
        .item   (hdr_item)
    );

endmodule

>>> src/wsfhp_front.sv
// Byte-level header parser: collects header fields and pushes complete headers.
module wsfhp_front
    import wsfhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  rx_item_t  item,
    output hdr_push_t push
);

    logic [3:0]  byte_index_reg,   byte_index_next;
    logic [7:0]  first_byte_reg,   first_byte_next;
    logic [6:0]  length_code_reg,  length_code_next;
    logic        mask_flag_reg,    mask_flag_next;
    logic [63:0] length_accum_reg, length_accum_next;
    logic [31:0] key_accum_reg,    key_accum_next;

    logic [3:0] ext_cur;
    logic [3:0] ext_new;
    logic [3:0] hdr_len_cur;
    logic [3:0] hdr_len_new;
    logic [3:0] index_inc;
    logic       done;

    always_comb
    begin
        ext_cur     = ext_len(length_code_reg);
        hdr_len_cur = BASE_HDR_LEN + ext_cur + (mask_flag_reg ? KEY_LEN : 4'd0);
        index_inc   = byte_index_reg + 4'd1;

        byte_index_next   = byte_index_reg;
        first_byte_next   = first_byte_reg;
        length_code_next  = length_code_reg;
        mask_flag_next    = mask_flag_reg;
        length_accum_next = length_accum_reg;
        key_accum_next    = key_accum_reg;
        done              = 1'b0;

        if (take)
        begin
            priority if (item.frame_start)
            begin
                // Abandon any open header and start afresh
                first_byte_next   = item.data_byte;
                length_code_next  = 7'd0;
                mask_flag_next    = 1'b0;
                length_accum_next = 64'd0;
                key_accum_next    = 32'd0;
                byte_index_next   = 4'd1;
            end
            else if (byte_index_reg == 4'd0)
            begin
                // Drop bytes outside a header
            end
            else if (byte_index_reg == 4'd1)
            begin
                mask_flag_next   = item.data_byte[7];
                length_code_next = item.data_byte[6:0] & LEN_MASK;
                byte_index_next  = 4'd2;
                done = (ext_len(length_code_next) == 4'd0) && !mask_flag_next;
            end
            else
            begin
                if (byte_index_reg < BASE_HDR_LEN + ext_cur)
                begin
                    length_accum_next = {length_accum_reg[55:0], item.data_byte};
                end
                else
                begin
                    key_accum_next = {key_accum_reg[23:0], item.data_byte};
                end
                byte_index_next = index_inc;
                done = (index_inc >= hdr_len_cur);
            end
            if (done)
            begin
                byte_index_next = 4'd0;
            end
        end

        ext_new     = ext_len(length_code_next);
        hdr_len_new = BASE_HDR_LEN + ext_new + (mask_flag_next ? KEY_LEN : 4'd0);

        push.valid              = done;
        push.rec.fin            = first_byte_next[7];
        push.rec.opcode         = first_byte_next[3:0] & OPCODE_MASK;
        push.rec.masked         = mask_flag_next;
        push.rec.payload_length = (ext_new == 4'd0) ? {57'd0, length_code_next}
                                                    : length_accum_next;
        push.rec.masking_key    = mask_flag_next ? key_accum_next : 32'd0;
        push.rec.header_length  = hdr_len_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= 4'd0;
            first_byte_reg   <= 8'd0;
            length_code_reg  <= 7'd0;
            mask_flag_reg    <= 1'b0;
            length_accum_reg <= 64'd0;
            key_accum_reg    <= 32'd0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            first_byte_reg   <= first_byte_next;
            length_code_reg  <= length_code_next;
            mask_flag_reg    <= mask_flag_next;
            length_accum_reg <= length_accum_next;
            key_accum_reg    <= key_accum_next;
        end
    end

endmodule

>>> src/wsfhp_queue.sv
// Short queue of parsed headers between the parser and the output stage.
module wsfhp_queue
    import wsfhp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  hdr_push_t     push,
    input  logic          pop,
    output queue_status_t status,
    output hdr_rec_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hdr_rec_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head         = entries[rd_ptr_reg];

    always_comb
    begin
        do_push     = push.valid && !status.full;
        do_pop      = pop && !status.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/wsfhp_back.sv
// Output stage: adds the frame length and holds the result item until taken.
module wsfhp_back
    import wsfhp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t status,
    input  hdr_rec_t      head,
    output logic          pop,
    output logic          valid,
    input  logic          ready,
    output hdr_item_t     item
);

    logic      valid_reg, valid_next;
    hdr_item_t item_reg,  item_next;
    logic [64:0] sum;

    assign valid = valid_reg;
    assign item  = item_reg;

    always_comb
    begin
        pop = !status.empty && (!valid_reg || ready);
        sum = {1'b0, head.payload_length} + {61'd0, head.header_length};

        item_next.fin            = head.fin;
        item_next.opcode         = head.opcode;
        item_next.masked         = head.masked;
        item_next.payload_length = head.payload_length;
        item_next.masking_key    = head.masking_key;
        item_next.header_length  = head.header_length;
        // Saturate on carry out
        item_next.frame_length   = sum[64] ? {64{1'b1}} : sum[63:0];

        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule
